// ----- rtl/wlss_pkg.sv -----
// Package for the window least-squares slope core.
// Field widths, reset values and arithmetic constants; no dependencies.
package wlss_pkg;

    localparam int DIST_W         = 16;
    localparam int TIME_W         = 32;
    localparam int INTERVAL_W     = 10;
    localparam int SLOPE_W        = 31;
    localparam int FILL_W         = 4;

    localparam int WINDOW_DEF     = 10;
    localparam logic [INTERVAL_W-1:0] INTERVAL_RESET = INTERVAL_W'(20);

    // ms-to-s factor times the Q4 scale of the slope
    localparam int SCALE_W        = 14;
    localparam logic [SCALE_W-1:0] SLOPE_SCALE = SCALE_W'(16000);

    // quotient bits produced by the serial divider
    localparam int QUOT_W         = 31;

endpackage

// ----- rtl/wlss_if.sv -----
// Request and result channel interfaces of the window least-squares slope core.
// Depends on wlss_pkg for the field widths.
interface wlss_in_if import wlss_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [DIST_W-1:0]   distance_mm;
    logic [TIME_W-1:0]   time_ms;
    logic                restart;

    modport source (output valid, distance_mm, time_ms, restart, input ready);
    modport sink   (input valid, distance_mm, time_ms, restart, output ready);
endinterface

interface wlss_out_if import wlss_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SLOPE_W-1:0]  slope_q4;
    logic                       slope_valid;
    logic                       sample_stored;
    logic [FILL_W-1:0]          fill_count;

    modport source (output valid, slope_q4, slope_valid, sample_stored, fill_count,
                    input ready);
    modport sink   (input valid, slope_q4, slope_valid, sample_stored, fill_count,
                    output ready);
endinterface

// ----- rtl/window_least_squares_slope_core.sv -----
// Window least-squares slope core: ring of distance samples, sums over the
// window, exact integer slope via a restoring serial divider.
// Sequence for n >= 2 held samples: accept, summing through the ring RAM
// read port, the product states S_MUL1, S_MUL2 and S_MUL3, 31 divider steps,
// output load; with fewer than two samples the core goes from accept
// straight to the output load. One request at a time: the next is taken
// once the result is in the output register, and a full output register
// stalls the core. Synchronous reset clears the fill count, write slot and
// last-store time and sets the interval to 20; ring contents are left
// undefined.
module window_least_squares_slope_core
    import wlss_pkg::*;
#(
    parameter int WINDOW = WINDOW_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [INTERVAL_W-1:0] i_cfg_wdata,
    wlss_in_if.sink               i_req,
    wlss_out_if.source            o_res
);

    localparam int TW    = $clog2(WINDOW);
    localparam int LW    = $clog2(WINDOW + 1);
    localparam int SYW   = DIST_W + LW;
    localparam int STW   = 2 * LW;
    localparam int STTW  = 3 * LW;
    localparam int STYW  = DIST_W + 2 * LW;
    localparam int PW    = DIST_W + 3 * LW;
    localparam int DW    = 4 * LW;
    localparam int DENW  = DW + INTERVAL_W;
    localparam int DVW   = PW + SCALE_W;
    localparam int HIW   = DVW - QUOT_W;
    localparam int CW    = $clog2(QUOT_W);

    typedef enum logic [2:0] {
        S_IDLE, S_ACC, S_MUL1, S_MUL2, S_MUL3, S_DIV, S_DONE
    } t_state;

    t_state                    r_state;
    logic [INTERVAL_W-1:0]     r_interval;
    logic [TW-1:0]             r_wslot;
    logic [LW-1:0]             r_held;
    logic [TIME_W-1:0]         r_last;
    logic                      r_stored;

    logic [TW-1:0]             r_rslot;
    logic [LW-1:0]             r_iss;
    logic                      r_pend;
    logic [TW-1:0]             r_t;
    logic [SYW-1:0]            r_sy;
    logic [STW-1:0]            r_st;
    logic [STTW-1:0]           r_stt;
    logic [STYW-1:0]           r_sty;

    logic [PW-1:0]             r_p1, r_p2;
    logic [DW-1:0]             r_p3, r_p4;
    logic                      r_neg;
    logic [PW-1:0]             r_mag;
    logic [DW-1:0]             r_dd;
    logic [DENW-1:0]           r_den;
    logic [DENW:0]             r_rem;
    logic [QUOT_W-1:0]         r_dvd;
    logic [CW-1:0]             r_cnt;
    logic                      r_valid;
    logic signed [SLOPE_W-1:0] r_slope;

    logic                      r_out_valid;
    logic signed [SLOPE_W-1:0] r_out_slope;
    logic                      r_out_svalid;
    logic                      r_out_stored;
    logic [FILL_W-1:0]         r_out_fill;

    logic                      w_accept;
    logic [TIME_W-1:0]         w_last_eff;
    logic [TW-1:0]             w_wslot_eff;
    logic [LW-1:0]             w_held_eff;
    logic [TIME_W-1:0]         w_elapsed;
    logic                      w_store;
    logic [TW-1:0]             n_wslot;
    logic [LW-1:0]             n_held;
    logic [DIST_W-1:0]         w_rdata;
    logic [TW+DIST_W-1:0]      w_ty;
    logic [2*TW-1:0]           w_tt;
    logic [PW:0]               w_num;
    logic [DVW-1:0]            w_dividend;
    logic [INTERVAL_W-1:0]     w_unit;
    logic [DENW:0]             w_trial;
    logic                      w_qbit;
    logic [QUOT_W-1:0]         w_quot;

    // ring of stored samples
    wlss_ram #(
        .WIDTH (DIST_W),
        .DEPTH (WINDOW)
    ) u_ring (
        .i_clk   (i_clk),
        .i_we    (w_accept && w_store),
        .i_waddr (w_wslot_eff),
        .i_wdata (i_req.distance_mm),
        .i_raddr (r_rslot),
        .o_rdata (w_rdata)
    );

    assign w_accept = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);

    // apply restart, then decide whether the interval has passed
    assign w_last_eff  = i_req.restart ? '0 : r_last;
    assign w_wslot_eff = i_req.restart ? '0 : r_wslot;
    assign w_held_eff  = i_req.restart ? '0 : r_held;
    assign w_elapsed   = i_req.time_ms - w_last_eff;
    assign w_store     = (w_elapsed >= TIME_W'(r_interval));

    always_comb begin
        n_wslot = w_wslot_eff;
        n_held  = w_held_eff;
        if (w_store) begin
            n_wslot = (w_wslot_eff == TW'(WINDOW - 1)) ? '0 : w_wslot_eff + TW'(1);
            if (w_held_eff < LW'(WINDOW)) begin
                n_held = w_held_eff + LW'(1);
            end
        end
    end

    // per-sample products for the running sums
    assign w_ty = {{DIST_W{1'b0}}, r_t} * {{TW{1'b0}}, w_rdata};
    assign w_tt = {{TW{1'b0}}, r_t} * {{TW{1'b0}}, r_t};

    // numerator difference, scaled dividend and slope time unit
    assign w_num      = {1'b0, r_p1} - {1'b0, r_p2};
    assign w_dividend = DVW'(r_mag) * DVW'(SLOPE_SCALE);
    assign w_unit     = (r_interval == '0) ? INTERVAL_W'(1) : r_interval;

    // one restoring divider step
    assign w_trial = {r_rem[DENW-1:0], r_dvd[QUOT_W-1]};
    assign w_qbit  = (w_trial >= {1'b0, r_den});
    assign w_quot  = {r_dvd[QUOT_W-2:0], w_qbit};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_interval  <= INTERVAL_RESET;
            r_wslot     <= '0;
            r_held      <= '0;
            r_last      <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_interval <= i_cfg_wdata;
            end
            // drop the result once taken; the done state reloads it itself
            if (o_res.ready && (r_state != S_DONE)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (w_accept) begin
                        r_wslot  <= n_wslot;
                        r_held   <= n_held;
                        r_stored <= w_store;
                        r_last   <= w_store ? i_req.time_ms : w_last_eff;
                        // oldest sample sits at slot 0 until the ring is full
                        r_rslot <= (n_held < LW'(WINDOW)) ? '0 : n_wslot;
                        r_iss   <= '0;
                        r_pend  <= 1'b0;
                        r_t     <= '0;
                        r_sy    <= '0;
                        r_st    <= '0;
                        r_stt   <= '0;
                        r_sty   <= '0;
                        if (n_held >= LW'(2)) begin
                            r_valid <= 1'b1;
                            r_state <= S_ACC;
                        end else begin
                            r_valid <= 1'b0;
                            r_slope <= '0;
                            r_state <= S_DONE;
                        end
                    end
                end

                S_ACC: begin
                    // issue the next ring read
                    if (r_iss < r_held) begin
                        r_rslot <= (r_rslot == TW'(WINDOW - 1)) ? '0 : r_rslot + TW'(1);
                        r_iss   <= r_iss + LW'(1);
                        r_pend  <= 1'b1;
                    end else begin
                        r_pend  <= 1'b0;
                    end
                    // accumulate the sample read last cycle
                    if (r_pend) begin
                        r_sy  <= r_sy + SYW'(w_rdata);
                        r_st  <= r_st + STW'(r_t);
                        r_stt <= r_stt + STTW'(w_tt);
                        r_sty <= r_sty + STYW'(w_ty);
                        r_t   <= r_t + TW'(1);
                        if (LW'(r_t) == r_held - LW'(1)) begin
                            r_state <= S_MUL1;
                        end
                    end
                end

                S_MUL1: begin
                    r_p1    <= PW'(r_held) * PW'(r_sty);
                    r_p2    <= PW'(r_st) * PW'(r_sy);
                    r_p3    <= DW'(r_held) * DW'(r_stt);
                    r_p4    <= DW'(r_st) * DW'(r_st);
                    r_state <= S_MUL2;
                end

                S_MUL2: begin
                    r_neg   <= w_num[PW];
                    r_mag   <= w_num[PW] ? PW'(-w_num) : w_num[PW-1:0];
                    r_dd    <= r_p3 - r_p4;
                    r_state <= S_MUL3;
                end

                S_MUL3: begin
                    r_den   <= DENW'(r_dd) * DENW'(w_unit);
                    r_rem   <= {{(DENW + 1 - HIW){1'b0}}, w_dividend[DVW-1:QUOT_W]};
                    r_dvd   <= w_dividend[QUOT_W-1:0];
                    r_cnt   <= '0;
                    r_state <= S_DIV;
                end

                S_DIV: begin
                    r_rem <= w_qbit ? (w_trial - {1'b0, r_den}) : w_trial;
                    r_dvd <= w_quot;
                    r_cnt <= r_cnt + CW'(1);
                    if (r_cnt == CW'(QUOT_W - 1)) begin
                        r_slope <= r_neg ? -$signed(w_quot) : $signed(w_quot);
                        r_state <= S_DONE;
                    end
                end

                S_DONE: begin
                    // hold until the output register is free
                    if (!r_out_valid || o_res.ready) begin
                        r_out_valid  <= 1'b1;
                        r_out_slope  <= r_slope;
                        r_out_svalid <= r_valid;
                        r_out_stored <= r_stored;
                        r_out_fill   <= FILL_W'(r_held);
                        r_state      <= S_IDLE;
                    end
                end

                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_res.valid         = r_out_valid;
    assign o_res.slope_q4      = r_out_slope;
    assign o_res.slope_valid   = r_out_svalid;
    assign o_res.sample_stored = r_out_stored;
    assign o_res.fill_count    = r_out_fill;

endmodule

// ----- rtl/wlss_ram.sv -----
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module wlss_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 10
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port and registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
